[src/brs_pkg.sv]
// shared types and constants of the bilinear rgb sampler
package brs_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned FracBits   = 8;

  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned BankAw     = (ColW - 1) + (RowW - 1);
  localparam int unsigned BankDepth  = 2 ** BankAw;
  localparam int unsigned NumBanks   = 4;

  localparam int unsigned CoordW     = 17;
  localparam int unsigned IntW       = CoordW - 1 - FracBits;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned CfgW       = 9;

  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = FifoPtrW + 1;

  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

  typedef enum logic [0:0] {
    FuncWrite  = 1'b0,
    FuncSample = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic            en;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    pixel_t          data;
  } store_wr_t;

  typedef struct packed {
    logic [IntW:0] x0;
    logic [IntW:0] x1;
    logic [IntW:0] y0;
    logic [IntW:0] y1;
  } store_rd_t;

  typedef struct packed {
    pixel_t color;
    logic   in_range;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

[src/brs_pixel_store.sv]
// pixel store banked by even and odd row and column, registered read data
module brs_pixel_store import brs_pkg::*; (
  input  logic              clk_i,
  input  store_wr_t         wr_i,
  input  store_rd_t         rd_i,
  output pixel_t [NumBanks-1:0] rdata_o
);

  logic [1:0]        wr_bank;
  logic [BankAw-1:0] wr_addr;

  assign wr_bank = {wr_i.row[0], wr_i.col[0]};
  assign wr_addr = {wr_i.row[RowW-1:1], wr_i.col[ColW-1:1]};

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    localparam logic [1:0] BankId = 2'(b);

    pixel_t            mem [BankDepth];
    pixel_t            rdata_q;
    logic [IntW:0]     col_sel;
    logic [IntW:0]     row_sel;
    logic [BankAw-1:0] rd_addr;

    // pick whichever neighbor coordinate has this bank's parity
    assign col_sel = (rd_i.x0[0] == BankId[0]) ? rd_i.x0 : rd_i.x1;
    assign row_sel = (rd_i.y0[0] == BankId[1]) ? rd_i.y0 : rd_i.y1;
    assign rd_addr = {row_sel[RowW-1:1], col_sel[ColW-1:1]};

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_bank == BankId)) begin
        mem[wr_addr] <= wr_i.data;
      end
      rdata_q <= mem[rd_addr];
    end

    assign rdata_o[b] = rdata_q;
  end

endmodule

[src/brs_result_fifo.sv]
// small result queue between the blend pipeline and the output stream
module brs_result_fifo import brs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  result_t      data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output result_t      data_o,
  output fifo_status_t status_o
);

  result_t             entries_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FifoCntW'(push_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o        = (cnt_q != '0);
  assign data_o         = entries_q[rd_ptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == FifoCntW'(FifoDepth));

endmodule

[src/bilinear_rgb_sampler_unit.sv]
// a sample result passes the registered store read and stage 1, stage 2, then the result queue; a write gives none
// throughput: one request per cycle while credits remain, set by the four-bank pixel store reading all corners at once
// a credit counter bounds sample requests in flight to the depth of the 4-entry result queue
// reset: control and queue cleared, image width and height set to 256
// reset: pixel store is not initialized and holds no valid pixel until written
module bilinear_rgb_sampler_unit import brs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_x[16:0] sample_y[33:17] pixel_col[41:34] pixel_row[49:42]
  // red_in[57:50] green_in[65:58] blue_in[73:66] zero[79:74]
  input  logic [79:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out[7:0] green_out[15:8] blue_out[23:16]
  output logic [23:0] m_axis_tdata,
  // in_range[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CmpW = (CfgW > IntW + 1) ? CfgW : IntW + 1;
  localparam int unsigned TopW = ChanW + FracBits;
  localparam int unsigned VW   = ChanW + 2 * FracBits;
  localparam logic [FracBits:0] WeightOne = (FracBits + 1)'(1) << FracBits;

  // configuration
  logic [CfgW-1:0] width_q, width_d;
  logic [CfgW-1:0] height_q, height_d;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        RegWidth:  width_d  = pwdata[CfgW-1:0];
        RegHeight: height_d = pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // request decode
  logic                s_fire;
  logic                sample_acc;
  logic [CoordW-1:0]   sample_x, sample_y;
  logic [FracBits-1:0] fx, fy;
  logic [IntW-1:0]     x0, y0;
  logic [IntW:0]       x1, y1;
  logic                fx_nz, fy_nz;
  logic [CfgW-1:0]     w_eff, h_eff;
  logic                in_range;
  store_wr_t           store_wr;
  store_rd_t           store_rd;
  pixel_t [NumBanks-1:0] bank_rdata;

  assign s_fire     = s_axis_tvalid & s_axis_tready;
  assign sample_acc = s_fire & (func_e'(s_axis_tuser) == FuncSample);
  assign sample_x   = s_axis_tdata[16:0];
  assign sample_y   = s_axis_tdata[33:17];

  assign x0    = sample_x[CoordW-2:FracBits];
  assign y0    = sample_y[CoordW-2:FracBits];
  assign fx    = sample_x[FracBits-1:0];
  assign fy    = sample_y[FracBits-1:0];
  assign fx_nz = (fx != '0);
  assign fy_nz = (fy != '0);
  assign x1    = {1'b0, x0} + (IntW + 1)'(fx_nz);
  assign y1    = {1'b0, y0} + (IntW + 1)'(fy_nz);

  assign w_eff = (width_q  > CfgW'(MaxWidth))  ? CfgW'(MaxWidth)  : width_q;
  assign h_eff = (height_q > CfgW'(MaxHeight)) ? CfgW'(MaxHeight) : height_q;

  assign in_range = !sample_x[CoordW-1] && !sample_y[CoordW-1]
                 && (CmpW'(x1) < CmpW'(w_eff)) && (CmpW'(y1) < CmpW'(h_eff));

  assign store_wr.en      = s_fire & (func_e'(s_axis_tuser) == FuncWrite);
  assign store_wr.col     = s_axis_tdata[34 +: ColW];
  assign store_wr.row     = s_axis_tdata[42 +: RowW];
  assign store_wr.data[0] = s_axis_tdata[57:50];
  assign store_wr.data[1] = s_axis_tdata[65:58];
  assign store_wr.data[2] = s_axis_tdata[73:66];

  assign store_rd.x0 = {1'b0, x0};
  assign store_rd.x1 = x1;
  assign store_rd.y0 = {1'b0, y0};
  assign store_rd.y1 = y1;

  brs_pixel_store u_store (
    .clk_i   (clk_i),
    .wr_i    (store_wr),
    .rd_i    (store_rd),
    .rdata_o (bank_rdata)
  );

  // stage 1: corner select and horizontal blend
  logic                s1_valid_q;
  logic                s1_in_range_q;
  logic [FracBits-1:0] s1_fx_q, s1_fy_q;
  logic                s1_px_q, s1_py_q, s1_fxnz_q, s1_fynz_q;
  pixel_t              p00, p10, p01, p11;
  logic [FracBits:0]   wx0;
  logic [NumChan-1:0][TopW-1:0] top_d, bot_d;

  always_ff @(posedge clk_i) begin
    s1_in_range_q <= in_range;
    s1_fx_q       <= fx;
    s1_fy_q       <= fy;
    s1_px_q       <= x0[0];
    s1_py_q       <= y0[0];
    s1_fxnz_q     <= fx_nz;
    s1_fynz_q     <= fy_nz;
  end

  assign p00 = bank_rdata[{s1_py_q, s1_px_q}];
  assign p10 = bank_rdata[{s1_py_q, s1_px_q ^ s1_fxnz_q}];
  assign p01 = bank_rdata[{s1_py_q ^ s1_fynz_q, s1_px_q}];
  assign p11 = bank_rdata[{s1_py_q ^ s1_fynz_q, s1_px_q ^ s1_fxnz_q}];
  assign wx0 = WeightOne - {1'b0, s1_fx_q};

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      top_d[ch] = TopW'(p00[ch]) * TopW'(wx0) + TopW'(p10[ch]) * TopW'(s1_fx_q);
      bot_d[ch] = TopW'(p01[ch]) * TopW'(wx0) + TopW'(p11[ch]) * TopW'(s1_fx_q);
    end
  end

  // stage 2: vertical blend, black color when out of range
  logic                s2_valid_q;
  logic                s2_in_range_q;
  logic [FracBits-1:0] s2_fy_q;
  logic [NumChan-1:0][TopW-1:0] s2_top_q, s2_bot_q;
  logic [FracBits:0]   wy0;
  logic [VW-1:0]       blend [NumChan];
  result_t             result;

  always_ff @(posedge clk_i) begin
    s2_in_range_q <= s1_in_range_q;
    s2_fy_q       <= s1_fy_q;
    s2_top_q      <= top_d;
    s2_bot_q      <= bot_d;
  end

  assign wy0 = WeightOne - {1'b0, s2_fy_q};

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      blend[ch] = VW'(s2_top_q[ch]) * VW'(wy0) + VW'(s2_bot_q[ch]) * VW'(s2_fy_q);
      result.color[ch] = s2_in_range_q ? blend[ch][VW-1 -: ChanW] : '0;
    end
    result.in_range = s2_in_range_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= sample_acc;
      s2_valid_q <= s1_valid_q;
    end
  end

  // result queue and credits
  logic                pop;
  result_t             fifo_data;
  fifo_status_t        fifo_status;
  logic [FifoCntW-1:0] inflight_q, inflight_d;

  brs_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (s2_valid_q),
    .data_i   (result),
    .pop_i    (pop),
    .valid_o  (m_axis_tvalid),
    .data_o   (fifo_data),
    .status_o (fifo_status)
  );

  assign pop          = m_axis_tvalid & m_axis_tready;
  assign m_axis_tdata = fifo_data.color;
  assign m_axis_tuser = fifo_data.in_range;

  assign s_axis_tready = (inflight_q < FifoCntW'(FifoDepth));
  assign inflight_d    = inflight_q + FifoCntW'(sample_acc) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= FifoCntW'(FifoDepth))
    else $error("requests in flight exceed result queue depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> !fifo_status.full)
    else $error("result pushed into full queue");

  a_black_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out of range result is not black");

  a_sample_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_acc |-> ##2 s2_valid_q)
    else $error("sample request did not reach the queue in time");
`endif

endmodule
